/* hdl/aps_pkg.sv */
package aps_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    localparam int IN_SLOT_W  = 6;
    localparam int ID_W       = 16;
    localparam int PRIO_W     = 4;
    localparam int SLEEP_W    = 16;
    localparam int AGE_W      = 16;
    localparam int RATIO_W    = 8;
    localparam int PROD_W     = PRIO_W + RATIO_W;
    localparam int SCORE_W    = AGE_W + 1;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    localparam logic [PRIO_W-1:0]  MAX_PRIORITY_RST   = 4'd4;
    localparam logic [RATIO_W-1:0] PRIORITY_RATIO_RST = 8'd2;

    typedef logic [1:0] command_t;
    localparam command_t CMD_SCHEDULE = 2'd0;
    localparam command_t CMD_WRITE    = 2'd1;
    localparam command_t CMD_FREE     = 2'd2;
    localparam command_t CMD_UNUSED   = 2'd3;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_MAX_PRIORITY   = 4'd0;
    localparam cfg_index_t CFG_PRIORITY_RATIO = 4'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [SLEEP_W-1:0] sleep;
        logic               blocked;
        logic [AGE_W-1:0]   age;
    } slot_rec_t;

    // controller to datapath
    typedef struct packed {
        logic write_slot;
        logic free_slot;
        logic scan_start;
        logic scan_issue;
        logic finish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic pipe_busy;
        logic out_busy;
    } dp_status_t;

endpackage

/* hdl/aps_ctrl.sv */
module aps_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  aps_pkg::command_t    s_command,
    input  aps_pkg::dp_status_t  status,
    output aps_pkg::dp_cmd_t     cmd
);

    aps_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aps_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            aps_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (s_command)
                        aps_pkg::CMD_SCHEDULE: begin
                            cmd.scan_start = 1'b1;
                            state_next     = aps_pkg::ST_SCAN;
                        end
                        aps_pkg::CMD_WRITE: cmd.write_slot = 1'b1;
                        aps_pkg::CMD_FREE:  cmd.free_slot  = 1'b1;
                        default: ;
                    endcase
                end
            end
            aps_pkg::ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last) begin
                    state_next = aps_pkg::ST_DRAIN;
                end
            end
            aps_pkg::ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = aps_pkg::ST_FINISH;
                end
            end
            aps_pkg::ST_FINISH: begin
                // hold the winner until the result register frees up
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = aps_pkg::ST_IDLE;
                end
            end
            default: state_next = aps_pkg::ST_IDLE;
        endcase
    end

endmodule

/* hdl/aps_datapath.sv */
module aps_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  aps_pkg::dp_cmd_t                  cmd,
    output aps_pkg::dp_status_t               status,
    input  logic [aps_pkg::IN_SLOT_W-1:0]     s_slot,
    input  logic [aps_pkg::ID_W-1:0]          s_task_id,
    input  logic [aps_pkg::PRIO_W-1:0]        s_task_priority,
    input  logic signed [aps_pkg::SLEEP_W-1:0] s_sleep_ticks,
    input  logic                              s_is_blocked,
    input  logic                              cfg_valid,
    input  aps_pkg::cfg_index_t               cfg_index,
    input  logic [aps_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [aps_pkg::IN_SLOT_W-1:0]     m_chosen_slot,
    output logic [aps_pkg::ID_W-1:0]          m_chosen_id,
    output logic                              m_picked_idle
);

    localparam int SW = aps_pkg::SLOT_W;

    // configuration
    logic [aps_pkg::PRIO_W-1:0]  max_prio_reg;
    logic [aps_pkg::RATIO_W-1:0] ratio_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_prio_reg <= aps_pkg::MAX_PRIORITY_RST;
            ratio_reg    <= aps_pkg::PRIORITY_RATIO_RST;
        end else if (cfg_valid) begin
            if (cfg_index == aps_pkg::CFG_MAX_PRIORITY) begin
                max_prio_reg <= cfg_data[aps_pkg::PRIO_W-1:0];
            end
            if (cfg_index == aps_pkg::CFG_PRIORITY_RATIO) begin
                ratio_reg <= cfg_data[aps_pkg::RATIO_W-1:0];
            end
        end
    end

    // slot table
    aps_pkg::slot_rec_t mem [aps_pkg::SLOT_COUNT];
    aps_pkg::slot_rec_t rd_data_reg;
    aps_pkg::slot_rec_t wr_data;
    logic [SW-1:0]      wr_addr;
    logic               wr_en;
    logic [aps_pkg::SLOT_COUNT-1:0] in_use_reg;

    logic [SW-1:0] in_idx;
    logic          in_range;
    assign in_idx   = SW'(s_slot);
    assign in_range = (32'(s_slot) < aps_pkg::SLOT_COUNT);

    // scan pipeline
    logic [SW-1:0] cnt_reg;
    logic          s1_v_reg;
    logic [SW-1:0] s1_slot_reg;
    logic          s2_v_reg;
    logic [SW-1:0] s2_slot_reg;
    logic [aps_pkg::SCORE_W-1:0] s2_score_reg;
    logic [aps_pkg::ID_W-1:0]    s2_id_reg;
    logic [aps_pkg::PRIO_W-1:0]  s2_prio_reg;
    logic [aps_pkg::SLEEP_W-1:0] s2_sleep_reg;

    logic                        found_reg;
    logic [SW-1:0]               best_slot_reg;
    logic [aps_pkg::SCORE_W-1:0] best_score_reg;
    logic [aps_pkg::ID_W-1:0]    best_id_reg;
    logic [aps_pkg::PRIO_W-1:0]  best_prio_reg;
    logic [aps_pkg::SLEEP_W-1:0] best_sleep_reg;

    // stage one: age or wake the slot and score it
    aps_pkg::slot_rec_t          upd;
    logic                        asleep;
    logic                        ready;
    logic [aps_pkg::PRIO_W-1:0]  prio_cl;
    logic [aps_pkg::PRIO_W-1:0]  prio_diff;
    logic [aps_pkg::PROD_W-1:0]  prod;
    logic [aps_pkg::SCORE_W-1:0] score;

    always_comb begin
        upd    = rd_data_reg;
        asleep = rd_data_reg.sleep[aps_pkg::SLEEP_W-1];
        ready  = !asleep && !rd_data_reg.blocked;
        if (asleep) begin
            upd.sleep = rd_data_reg.sleep + 1'b1;
        end else if (ready && rd_data_reg.age != aps_pkg::AGE_MAX) begin
            upd.age = rd_data_reg.age + 1'b1;
        end
        prio_cl   = (rd_data_reg.prio > max_prio_reg) ? max_prio_reg : rd_data_reg.prio;
        prio_diff = max_prio_reg - prio_cl;
        prod      = aps_pkg::PROD_W'(prio_diff) * aps_pkg::PROD_W'(ratio_reg);
        score     = aps_pkg::SCORE_W'(prod) + aps_pkg::SCORE_W'(upd.age);
    end

    // one write port shared by slot writes, scan write-back and winner update
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = s1_slot_reg;
        wr_data = upd;
        priority if (cmd.write_slot) begin
            wr_en           = in_range;
            wr_addr         = in_idx;
            wr_data.id      = s_task_id;
            wr_data.prio    = s_task_priority;
            wr_data.sleep   = s_sleep_ticks;
            wr_data.blocked = s_is_blocked;
            wr_data.age     = '0;
        end else if (cmd.finish) begin
            wr_en           = found_reg;
            wr_addr         = best_slot_reg;
            wr_data.id      = best_id_reg;
            wr_data.prio    = best_prio_reg;
            wr_data.sleep   = best_sleep_reg;
            wr_data.blocked = 1'b0;
            wr_data.age     = '0;
        end else begin
            wr_en = s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[cnt_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
        end else if (in_range && (cmd.write_slot || cmd.free_slot)) begin
            in_use_reg[in_idx] <= cmd.write_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            s1_v_reg <= cmd.scan_issue && in_use_reg[cnt_reg];
            s2_v_reg <= s1_v_reg && ready;
            if (cmd.scan_start) begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
            end else begin
                if (cmd.scan_issue) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (s2_v_reg) begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_slot_reg  <= cnt_reg;
        s2_slot_reg  <= s1_slot_reg;
        s2_score_reg <= score;
        s2_id_reg    <= upd.id;
        s2_prio_reg  <= upd.prio;
        s2_sleep_reg <= upd.sleep;
        // strict compare keeps the lowest slot on a tie
        if (s2_v_reg && (!found_reg || s2_score_reg > best_score_reg)) begin
            best_slot_reg  <= s2_slot_reg;
            best_score_reg <= s2_score_reg;
            best_id_reg    <= s2_id_reg;
            best_prio_reg  <= s2_prio_reg;
            best_sleep_reg <= s2_sleep_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.finish) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_chosen_slot <= found_reg ? aps_pkg::IN_SLOT_W'(best_slot_reg) : '0;
            m_chosen_id   <= found_reg ? best_id_reg : '0;
            m_picked_idle <= !found_reg;
        end
    end

    assign status.scan_last = (cnt_reg == SW'(aps_pkg::SLOT_COUNT - 1));
    assign status.pipe_busy = s1_v_reg || s2_v_reg;
    assign status.out_busy  = m_valid && !m_ready;

endmodule

/* hdl/aging_priority_scheduler_top.sv */
// write, free and unused commands give no result
// schedule: accept, one slot read per cycle over all 64 slots, pipeline drain, then
// the winner update, which also registers the result; no new request is taken before a schedule
// is through, and the scan rate is set by the single table read port;
// a result still waiting at the output holds the next schedule in its last cycle
// reset (aresetn, synchronous, active low) frees every slot and loads the register defaults
module aging_priority_scheduler_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_command,
    input  logic [aps_pkg::IN_SLOT_W-1:0]      s_slot,
    input  logic [aps_pkg::ID_W-1:0]           s_task_id,
    input  logic [aps_pkg::PRIO_W-1:0]         s_task_priority,
    input  logic signed [aps_pkg::SLEEP_W-1:0] s_sleep_ticks,
    input  logic                               s_is_blocked,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [aps_pkg::IN_SLOT_W-1:0]      m_chosen_slot,
    output logic [aps_pkg::ID_W-1:0]           m_chosen_id,
    output logic                               m_picked_idle,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [aps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    aps_pkg::dp_cmd_t    cmd;
    aps_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    aps_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .status    (status),
        .cmd       (cmd)
    );

    aps_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_slot          (s_slot),
        .s_task_id       (s_task_id),
        .s_task_priority (s_task_priority),
        .s_sleep_ticks   (s_sleep_ticks),
        .s_is_blocked    (s_is_blocked),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chosen_slot   (m_chosen_slot),
        .m_chosen_id     (m_chosen_id),
        .m_picked_idle   (m_picked_idle)
    );

endmodule

/* hdl/aps_checker.sv */
module aps_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic [1:0]                         s_command,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [aps_pkg::IN_SLOT_W-1:0]      m_chosen_slot,
    input logic [aps_pkg::ID_W-1:0]           m_chosen_id,
    input logic                               m_picked_idle
);

    // reset empties the result register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // idle result carries slot zero and id zero
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_picked_idle) |-> (m_chosen_slot == '0 && m_chosen_id == '0))
        else $error("idle result with nonzero slot or id");

    // a schedule request occupies the block while the table is scanned
    a_sched_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == aps_pkg::CMD_SCHEDULE) |=> !s_ready)
        else $error("request taken during a scan");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_chosen_slot)
            && $stable(m_chosen_id) && $stable(m_picked_idle)))
        else $error("stalled result changed");

endmodule

bind aging_priority_scheduler_top aps_checker u_aps_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_command     (s_command),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_chosen_slot (m_chosen_slot),
    .m_chosen_id   (m_chosen_id),
    .m_picked_idle (m_picked_idle)
);
